/* design/mst_pkg.sv */
`default_nettype none
package mst_pkg;
	localparam int NV = 64;
	localparam int VB = 6;
	localparam int WB = 16;
	localparam int AB = 2 * VB;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]    mode;
		logic [5:0]    edge_from;
		logic [5:0]    edge_to;
		logic [15:0]   edge_weight;
		logic [5:0]    start_vertex;
	} in_item_t;

	typedef struct packed {
		logic          run_valid;
		logic [5:0]    tree_vertex;
		logic [5:0]    parent_vertex;
		logic [15:0]   tree_edge_weight;
		logic          is_root;
		logic          last;
	} out_item_t;

	// adjacency memory access from the sequencer
	typedef struct packed {
		logic          rd;
		logic          wr;
		logic [AB-1:0] addr;
		logic [WB-1:0] wdata;
	} adj_req_t;
endpackage
`default_nettype wire

/* design/minimum_spanning_tree_engine.sv */
`default_nettype none
// Load: writes the edge in both directions, each a read then a conditional write (once for a
// self loop). Clear: a sweep that clears every entry of the edge table. Run: per tree vertex, a scan of
// all vertices (S_SCAN/S_SCANW) and a select pass (S_SEL/S_SELW), then an emit pass that
// may stall on the output. Directed run: emits one item marked last with run_valid low.
// One transaction at a time. Reset clears control state and flags, then sweeps the table.
module minimum_spanning_tree_engine (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire mst_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mst_pkg::out_item_t      out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_data
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_LD1   = 10'b0000000010,
		S_LD2   = 10'b0000000100,
		S_SCAN  = 10'b0000001000,
		S_SCANW = 10'b0000010000,
		S_SEL   = 10'b0000100000,
		S_SELW  = 10'b0001000000,
		S_EMIT  = 10'b0010000000,
		S_EMITW = 10'b0100000000,
		S_DIR   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic   directed_q;
	logic [mst_pkg::NV-1:0] reached_q, explored_q;
	logic [mst_pkg::WB-1:0] key_q [mst_pkg::NV];
	logic [mst_pkg::VB-1:0] par_q [mst_pkg::NV];
	logic [mst_pkg::WB-1:0] key_rd_q;
	logic [mst_pkg::VB-1:0] par_rd_q;
	logic [mst_pkg::VB-1:0] u_q, s_q, a_q, b_q;
	logic [mst_pkg::WB-1:0] w_q, best_q;
	logic [mst_pkg::VB:0]   v_q;
	logic                   found_q, pend_q;
	logic [mst_pkg::VB-1:0] pv_q;
	logic [mst_pkg::VB-1:0] vi;
	logic                   vend;
	mst_pkg::adj_req_t      req;
	logic                   clr;
	logic [mst_pkg::WB-1:0] rdata;
	logic                   rpresent;
	logic                   busy;
	logic                   out_load;
	logic [mst_pkg::NV-1:0] one_v;

	mst_adj_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.clr      (clr),
		.rdata    (rdata),
		.rpresent (rpresent),
		.busy     (busy)
	);

	assign one_v     = {{(mst_pkg::NV-1){1'b0}}, 1'b1};
	assign vi        = v_q[mst_pkg::VB-1:0];
	assign vend      = v_q[mst_pkg::VB];
	assign in_ready  = (state_q == S_IDLE) && !busy;
	assign cfg_ready = 1'b1;
	assign clr       = in_valid && in_ready && (in_data.mode == mst_pkg::MODE_CLEAR);
	assign out_load  = ((state_q == S_EMITW) || (state_q == S_DIR)) && (!out_valid || out_ready);

	always_comb begin
		req       = '0;
		req.wdata = w_q;
		unique case (state_q)
			S_LD1: begin
				req.rd   = 1'b1;
				req.addr = {a_q, b_q};
			end
			S_LD2: begin
				req.wr   = !rpresent || (w_q < rdata);
				req.addr = {a_q, b_q};
			end
			S_SCAN: begin
				req.rd   = !vend;
				req.addr = {u_q, vi};
			end
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		key_rd_q <= key_q[vi];
		par_rd_q <= par_q[vi];
		if (state_q == S_SCANW && !explored_q[pv_q] && rpresent
				&& (!reached_q[pv_q] || rdata < key_rd_q)) begin
			key_q[pv_q] <= rdata;
			par_q[pv_q] <= u_q;
		end else if (state_q == S_IDLE && in_valid && in_ready
				&& in_data.mode == mst_pkg::MODE_RUN) begin
			key_q[in_data.start_vertex] <= '0;
			par_q[in_data.start_vertex] <= in_data.start_vertex;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			directed_q <= 1'b0;
			reached_q  <= '0;
			explored_q <= '0;
			out_valid  <= 1'b0;
			out_data   <= '0;
			u_q <= '0; s_q <= '0; a_q <= '0; b_q <= '0; w_q <= '0; best_q <= '0;
			v_q <= '0; found_q <= 1'b0; pend_q <= 1'b0; pv_q <= '0;
		end else begin
			if (cfg_valid) begin
				directed_q <= cfg_data;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						a_q <= in_data.edge_from;
						b_q <= in_data.edge_to;
						w_q <= in_data.edge_weight;
						s_q <= in_data.start_vertex;
						u_q <= in_data.start_vertex;
						priority if (in_data.mode == mst_pkg::MODE_LOAD) begin
							state_q <= S_LD1;
						end else if (in_data.mode == mst_pkg::MODE_RUN) begin
							if (directed_q) begin
								state_q <= S_DIR;
							end else begin
								reached_q  <= one_v << in_data.start_vertex;
								explored_q <= one_v << in_data.start_vertex;
								v_q        <= '0;
								state_q    <= S_SCAN;
							end
						end
					end
				end
				S_LD1: state_q <= S_LD2;
				S_LD2: begin
					if (a_q != b_q) begin
						a_q     <= b_q;
						b_q     <= a_q;
						pend_q  <= ~pend_q;
						state_q <= pend_q ? S_IDLE : S_LD1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (vend) begin
						v_q     <= '0;
						found_q <= 1'b0;
						state_q <= S_SEL;
					end else begin
						pv_q    <= vi;
						v_q     <= v_q + 1'b1;
						state_q <= S_SCANW;
					end
				end
				S_SCANW: begin
					if (!explored_q[pv_q] && rpresent) begin
						reached_q[pv_q] <= 1'b1;
					end
					state_q <= S_SCAN;
				end
				S_SEL: begin
					if (vend) begin
						v_q <= '0;
						if (found_q) begin
							explored_q[u_q] <= 1'b1;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_EMIT;
						end
					end else begin
						pv_q    <= vi;
						v_q     <= v_q + 1'b1;
						state_q <= S_SELW;
					end
				end
				S_SELW: begin
					if (reached_q[pv_q] && !explored_q[pv_q]
							&& (!found_q || key_rd_q < best_q)) begin
						found_q <= 1'b1;
						u_q     <= pv_q;
						best_q  <= key_rd_q;
					end
					state_q <= S_SEL;
				end
				S_EMIT: begin
					if (vend) begin
						state_q <= S_IDLE;
					end else if (reached_q[vi]) begin
						state_q <= S_EMITW;
					end else begin
						v_q <= v_q + 1'b1;
					end
				end
				S_EMITW: begin
					if (out_load) begin
						out_data.run_valid        <= 1'b1;
						out_data.tree_vertex      <= vi;
						out_data.parent_vertex    <= par_rd_q;
						out_data.tree_edge_weight <= (vi == s_q) ? '0 : key_rd_q;
						out_data.is_root          <= (vi == s_q);
						out_data.last             <= (reached_q >> vi) == one_v;
						v_q                       <= v_q + 1'b1;
						state_q                   <= S_EMIT;
					end
				end
				S_DIR: begin
					if (out_load) begin
						out_data <= '{run_valid: 1'b0, tree_vertex: '0, parent_vertex: '0,
							tree_edge_weight: '0, is_root: 1'b0, last: 1'b1};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* design/mst_adj_mem.sv */
`default_nettype none
// adjacency weights with a present bit per entry; sweep every entry clear after reset and on clr
module mst_adj_mem (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mst_pkg::adj_req_t    req,
	input  wire logic                 clr,
	output logic [mst_pkg::WB-1:0]    rdata,
	output logic                      rpresent,
	output logic                      busy
);
	logic [mst_pkg::WB:0]   mem [mst_pkg::NV*mst_pkg::NV];
	logic [mst_pkg::WB:0]   rd_q;
	logic                   sweep_q;
	logic [mst_pkg::AB-1:0] sweep_addr_q;

	always_ff @(posedge clk) begin
		if (sweep_q) begin
			mem[sweep_addr_q] <= '0;
		end else if (req.wr) begin
			mem[req.addr] <= {1'b1, req.wdata};
		end
		if (req.rd) begin
			rd_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else if (sweep_q) begin
			sweep_addr_q <= sweep_addr_q + 1'b1;
			if (&sweep_addr_q) begin
				sweep_q <= 1'b0;
			end
		end else if (clr) begin
			sweep_q <= 1'b1;
		end
	end

	assign busy     = sweep_q;
	assign rdata    = rd_q[mst_pkg::WB-1:0];
	assign rpresent = rd_q[mst_pkg::WB];
endmodule
`default_nettype wire
